### sv/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg: shared constants, tables, types and helpers
// Fixed-point formats, CORDIC angle tables and the output clamp used by the
// lat/lng to Web Mercator pixel pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package mrc_pkg;

  // map geometry
  localparam int TILE_BITS = 8;
  localparam int MAX_ZOOM  = 23;

  // field widths
  localparam int LATW = 28;
  localparam int LNGW = 29;
  localparam int ZW   = 5;
  localparam int PXW  = 31;
  localparam int CFGW = 29;
  localparam int CIW  = 2;

  // shift amount tile bits plus zoom
  localparam int SHW = $clog2(TILE_BITS + MAX_ZOOM + 1);

  // angle constants in 2^-20 degree
  localparam logic signed [LNGW:0]   DEG180 = (LNGW+1)'(188743680);
  localparam logic signed [LATW-1:0] DEG90  = LATW'(94371840);

  // register reset values
  localparam logic signed [LATW-1:0] LAT_MIN_RST = LATW'(-89182572);
  localparam logic signed [LATW-1:0] LAT_MAX_RST = LATW'(89182572);
  localparam logic signed [LNGW-1:0] LNG_MIN_RST = LNGW'(-185597952);
  localparam logic signed [LNGW-1:0] LNG_MAX_RST = LNGW'(185597952);

  // register indexes
  localparam logic [CIW-1:0] REG_LAT_MIN = 2'd0;
  localparam logic [CIW-1:0] REG_LAT_MAX = 2'd1;
  localparam logic [CIW-1:0] REG_LNG_MIN = 2'd2;
  localparam logic [CIW-1:0] REG_LNG_MAX = 2'd3;

  // divide-by-45 unit
  localparam int DIVW  = 40;
  localparam int DLO   = 20;
  localparam int DHI   = DIVW - DLO;
  localparam int Q1W   = DHI - 5;
  localparam int DQW   = 36;
  localparam int DMW   = 27;
  localparam logic [DMW-1:0] DIV_M = DMW'(95443718);
  localparam logic [5:0]     DIV_D = 6'd45;

  // cordic formats
  localparam int SW  = 34;
  localparam int SZW = 32;
  localparam int HW  = 34;
  localparam int HZW = 33;
  localparam int SIN_STAGES = 30;
  localparam int HYP_STEPS  = 30;
  localparam int HYP_TABN   = 28;
  localparam int TW  = 36;
  localparam int QW  = 37;
  localparam int PRW = 40;

  localparam logic signed [SW-1:0] K_Q30   = SW'(652032874);
  localparam logic [31:0]          ONE_Q30 = 32'd1073741824;
  localparam logic [29:0]          LN2_Q30 = 30'd744261118;
  localparam logic [28:0]          INV_PI  = 29'd341782638;
  localparam logic [PXW-1:0]       OUT_MAX = {PXW{1'b1}};

  localparam logic [31:0] CIRC_TAB [SIN_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  localparam logic [31:0] HYP_TAB [HYP_TABN] = '{
    32'd589812981, 32'd274247419, 32'd134923406, 32'd67196451, 32'd33565361,
    32'd16778582, 32'd8388779, 32'd4194325, 32'd2097155, 32'd1048576,
    32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024,
    32'd512, 32'd256, 32'd128, 32'd64, 32'd32,
    32'd16, 32'd8, 32'd4
  };

  // sideband that rides along the cordic pipes
  typedef struct packed {
    logic           south;
    logic [SHW-1:0] sh;
    logic [PXW-1:0] px;
  } side_t;

  typedef struct packed {
    logic  pole;
    side_t side;
  } ymeta_t;

  // hyperbolic step to shift amount, steps 4 and 13 are repeated
  function automatic int hyp_sh(input int j);
    int r;
    if (j < 4) r = j + 1;
    else if (j == 4) r = 4;
    else if (j < 14) r = j;
    else if (j == 14) r = 13;
    else r = j - 1;
    return r;
  endfunction

  // clamp to map side minus one, then to the output range
  function automatic logic [PXW-1:0] clamp_px(input logic [PRW-1:0] p,
                                              input logic [SHW-1:0] sh);
    logic [PRW-1:0] top;
    logic [PRW-1:0] v;
    top = (PRW'(1) << sh) - PRW'(1);
    v = (p > top) ? top : p;
    if (v > PRW'(OUT_MAX)) v = PRW'(OUT_MAX);
    return v[PXW-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/mrc_if.sv
// ----------------------------------------------------------------------------
// mrc_if: request channels of the projection block
// Valid/ready channels for coordinate requests and pixel results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrc_in_if;
  import mrc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [LATW-1:0] latitude;
  logic signed [LNGW-1:0] longitude;
  logic        [ZW-1:0]   zoom_level;

  modport source (output valid, latitude, longitude, zoom_level, input ready);
  modport sink   (input valid, latitude, longitude, zoom_level, output ready);
endinterface

interface mrc_out_if;
  import mrc_pkg::*;
  logic           valid;
  logic           ready;
  logic [PXW-1:0] pixel_x;
  logic [PXW-1:0] pixel_y;

  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

`default_nettype wire

### sv/latlng_to_mercator_pixel.sv
// ----------------------------------------------------------------------------
// latlng_to_mercator_pixel: lat/lng to Web Mercator global pixel
// Top level: clipping, column math, sine and log pipelines, row output.
// ----------------------------------------------------------------------------
// Takes one coordinate request per clock and returns its global pixel column
// and row in order. The pipeline is the 30-stage sine CORDIC and the 30-step
// hyperbolic CORDIC, each one step per register stage, plus two stages of
// clipping and numerator setup, the three-stage divide by 45, two normalize
// stages, three scale stages and three stages of row math and output. A stall
// on the result side freezes the whole pipeline, so in_ch.ready follows
// out_ch.ready while a result is held. The user must write clip limits through
// the cfg port while no request is in flight; the block does not enforce it.
`default_nettype none

module latlng_to_mercator_pixel import mrc_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  mrc_in_if.sink               in_ch,
  mrc_out_if.source            out_ch,
  input  wire logic            cfg_we,
  input  wire logic [CIW-1:0]  cfg_index,
  input  wire logic [CFGW-1:0] cfg_wdata
);

  logic en;
  logic out_vld_r;

  // whole pipe moves when the output slot is free or taken
  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // clip limit registers
  logic signed [LATW-1:0] lat_min_r, lat_max_r;
  logic signed [LNGW-1:0] lng_min_r, lng_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_min_r <= LAT_MIN_RST;
      lat_max_r <= LAT_MAX_RST;
      lng_min_r <= LNG_MIN_RST;
      lng_max_r <= LNG_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LAT_MIN: lat_min_r <= cfg_wdata[LATW-1:0];
        REG_LAT_MAX: lat_max_r <= cfg_wdata[LATW-1:0];
        REG_LNG_MIN: lng_min_r <= cfg_wdata;
        REG_LNG_MAX: lng_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clip, pole clamp, zoom clamp
  logic signed [LATW-1:0] lat_c;
  logic signed [LNGW-1:0] lng_c;
  logic signed [LNGW:0]   v;
  logic [ZW-1:0]          zc;

  always_comb begin
    lat_c = in_ch.latitude;
    if (lat_c < lat_min_r) lat_c = lat_min_r;
    if (lat_c > lat_max_r) lat_c = lat_max_r;
    if (lat_c < -DEG90) lat_c = -DEG90;
    if (lat_c > DEG90) lat_c = DEG90;
    lng_c = in_ch.longitude;
    if (lng_c < lng_min_r) lng_c = lng_min_r;
    if (lng_c > lng_max_r) lng_c = lng_max_r;
    v = (LNGW+1)'(lng_c) + DEG180;
    zc = (in_ch.zoom_level > ZW'(MAX_ZOOM)) ? ZW'(MAX_ZOOM) : in_ch.zoom_level;
  end

  logic              p1_vld_r;
  logic [LATW-2:0]   p1_m_r;
  logic              p1_south_r;
  logic              p1_vneg_r;
  logic [LNGW-1:0]   p1_v_r;
  logic [SHW-1:0]    p1_sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p1_vld_r <= 1'b0;
    else if (en) p1_vld_r <= in_ch.valid && in_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_south_r <= lat_c < 0;
      p1_m_r     <= (lat_c < 0) ? (LATW-1)'(-lat_c) : lat_c[LATW-2:0];
      p1_vneg_r  <= v[LNGW];
      p1_v_r     <= v[LNGW-1:0];
      p1_sh_r    <= SHW'(TILE_BITS) + SHW'(zc);
    end
  end

  // numerators for angle and column divisions
  logic [63:0] nxw;
  assign nxw = (64'(p1_v_r) << p1_sh_r) + 64'(DEG180);

  logic            p2_vld_r;
  logic [DIVW-1:0] p2_na_r, p2_nx_r;
  logic            p2_south_r, p2_vneg_r;
  logic [SHW-1:0]  p2_sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p2_vld_r <= 1'b0;
    else if (en) p2_vld_r <= p1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_na_r    <= DIVW'({p1_m_r, 9'd0}) + DIVW'(22);
      p2_nx_r    <= nxw[23 +: DIVW];
      p2_south_r <= p1_south_r;
      p2_vneg_r  <= p1_vneg_r;
      p2_sh_r    <= p1_sh_r;
    end
  end

  logic [DQW-1:0] qa, qx;

  mrc_div45 u_div_ang (.clk(clk), .en(en), .n_i(p2_na_r), .q_o(qa));
  mrc_div45 u_div_col (.clk(clk), .en(en), .n_i(p2_nx_r), .q_o(qx));

  // sideband delay matching the dividers
  logic           d_vld_r   [3];
  logic           d_south_r [3];
  logic           d_vneg_r  [3];
  logic [SHW-1:0] d_sh_r    [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) d_vld_r[i] <= 1'b0;
    end else if (en) begin
      d_vld_r[0] <= p2_vld_r;
      for (int i = 1; i < 3; i++) d_vld_r[i] <= d_vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_south_r[0] <= p2_south_r;
      d_vneg_r[0]  <= p2_vneg_r;
      d_sh_r[0]    <= p2_sh_r;
      for (int i = 1; i < 3; i++) begin
        d_south_r[i] <= d_south_r[i-1];
        d_vneg_r[i]  <= d_vneg_r[i-1];
        d_sh_r[i]    <= d_sh_r[i-1];
      end
    end
  end

  // column is done here, it rides along as sideband
  side_t side_s;
  assign side_s.south = d_south_r[2];
  assign side_s.sh    = d_sh_r[2];
  assign side_s.px    = d_vneg_r[2] ? '0 : clamp_px(PRW'(qx), d_sh_r[2]);

  logic                 sin_vld;
  logic signed [SW-1:0] sin_y;
  side_t                sin_side;

  mrc_sin u_sin (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(d_vld_r[2]), .z_i(SZW'(qa)), .side_i(side_s),
    .vld_o(sin_vld), .y_o(sin_y), .side_o(sin_side)
  );

  logic          ln_vld;
  logic [TW-1:0] ln_t;
  ymeta_t        ln_meta;

  mrc_lnr u_lnr (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(sin_vld), .s_i(sin_y), .meta_i('{pole: 1'b0, side: sin_side}),
    .vld_o(ln_vld), .t_o(ln_t), .meta_o(ln_meta)
  );

  // row fraction in Q32
  logic [QW-1:0] q;
  always_comb begin
    if (ln_meta.side.south) q = QW'(ln_t) + (QW'(1) << 31);
    else if (ln_t >= (TW'(1) << 31)) q = '0;
    else q = (QW'(1) << 31) - QW'(ln_t);
  end

  logic          y1_vld_r;
  logic [QW-1:0] y1_q_r;
  ymeta_t        y1_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) y1_vld_r <= 1'b0;
    else if (en) y1_vld_r <= ln_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y1_q_r <= q;
      y1_m_r <= ln_meta;
    end
  end

  // scale by map side and round
  logic [71:0] yw;
  assign yw = (72'(y1_q_r) << y1_m_r.side.sh) + (72'(1) << 31);

  logic           y2_vld_r;
  logic [PRW-1:0] y2_p_r;
  ymeta_t         y2_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) y2_vld_r <= 1'b0;
    else if (en) y2_vld_r <= y1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y2_p_r <= yw[32 +: PRW];
      y2_m_r <= y1_m_r;
    end
  end

  // output register with pole handling
  logic [PXW-1:0] py;
  always_comb begin
    if (!y2_m_r.pole) py = clamp_px(y2_p_r, y2_m_r.side.sh);
    else if (y2_m_r.side.south) py = clamp_px(PRW'(33'h1_FFFF_FFFE), y2_m_r.side.sh);
    else py = '0;
  end

  logic [PXW-1:0] out_px_r, out_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= y2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_px_r <= y2_m_r.side.px;
      out_py_r <= py;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.pixel_x = out_px_r;
  assign out_ch.pixel_y = out_py_r;

endmodule

`default_nettype wire

### sv/mrc_div45.sv
// ----------------------------------------------------------------------------
// mrc_div45: pipelined divide by 45
// Three-stage reciprocal divider, upper and lower halves one after another.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_div45 import mrc_pkg::*; (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [DIVW-1:0] n_i,
  output logic      [DQW-1:0]  q_o
);

  logic [DHI+DMW-1:0] pa;
  logic [Q1W-1:0]     a_q1_r;
  logic [DHI-1:0]     a_hi_r;
  logic [DLO-1:0]     a_lo_r;
  logic [Q1W-1:0]     b_q1_r;
  logic [DLO+5:0]     b_m2_r;
  logic [DHI-1:0]     r1w;
  logic [DLO+5+DMW:0] pc;
  logic [DQW-1:0]     q_r;

  // upper half quotient
  assign pa = (DHI+DMW)'(n_i[DIVW-1:DLO]) * (DHI+DMW)'(DIV_M);

  always_ff @(posedge clk) begin
    if (en) begin
      a_q1_r <= pa[32 +: Q1W];
      a_hi_r <= n_i[DIVW-1:DLO];
      a_lo_r <= n_i[DLO-1:0];
    end
  end

  // upper remainder joins the lower half
  assign r1w = a_hi_r - DHI'(a_q1_r * DIV_D);

  always_ff @(posedge clk) begin
    if (en) begin
      b_q1_r <= a_q1_r;
      b_m2_r <= {r1w[5:0], a_lo_r};
    end
  end

  // lower half quotient
  assign pc = (DLO+6+DMW)'(b_m2_r) * (DLO+6+DMW)'(DIV_M);

  always_ff @(posedge clk) begin
    if (en) q_r <= DQW'({b_q1_r, pc[32 +: DLO]});
  end

  assign q_o = q_r;

endmodule

`default_nettype wire

### sv/mrc_sin.sv
// ----------------------------------------------------------------------------
// mrc_sin: circular CORDIC sine pipeline
// One rotation step per stage, angle in 2^-32 turn, sine out in Q30.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_sin import mrc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  vld_i,
  input  wire logic signed [SZW-1:0] z_i,
  input  wire side_t                 side_i,
  output logic                       vld_o,
  output logic signed [SW-1:0]       y_o,
  output side_t                      side_o
);

  logic               v_r    [SIN_STAGES];
  logic signed [SW-1:0]  x_r [SIN_STAGES];
  logic signed [SW-1:0]  y_r [SIN_STAGES];
  logic signed [SZW-1:0] z_r [SIN_STAGES];
  side_t              s_r    [SIN_STAGES];

  for (genvar g = 0; g < SIN_STAGES; g++) begin : g_stage
    logic                  va;
    logic signed [SW-1:0]  xa, ya;
    logic signed [SZW-1:0] za;
    side_t                 sa;

    if (g == 0) begin : g_head
      assign va = vld_i;
      assign xa = K_Q30;
      assign ya = '0;
      assign za = z_i;
      assign sa = side_i;
    end else begin : g_body
      assign va = v_r[g-1];
      assign xa = x_r[g-1];
      assign ya = y_r[g-1];
      assign za = z_r[g-1];
      assign sa = s_r[g-1];
    end

    // valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[g] <= 1'b0;
      else if (en) v_r[g] <= va;
    end

    // rotate toward zero residual angle
    always_ff @(posedge clk) begin
      if (en) begin
        if (za >= 0) begin
          x_r[g] <= xa - (ya >>> g);
          y_r[g] <= ya + (xa >>> g);
          z_r[g] <= za - $signed(CIRC_TAB[g]);
        end else begin
          x_r[g] <= xa + (ya >>> g);
          y_r[g] <= ya - (xa >>> g);
          z_r[g] <= za + $signed(CIRC_TAB[g]);
        end
        s_r[g] <= sa;
      end
    end
  end

  assign vld_o  = v_r[SIN_STAGES-1];
  assign y_o    = y_r[SIN_STAGES-1];
  assign side_o = s_r[SIN_STAGES-1];

endmodule

`default_nettype wire

### sv/mrc_lnr.sv
// ----------------------------------------------------------------------------
// mrc_lnr: Mercator log term pipeline
// Normalizes 1+sin and 1-sin, runs hyperbolic CORDIC for atanh, and scales
// the log ratio by 1/pi into a Q32 row offset.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_lnr import mrc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 vld_i,
  input  wire logic signed [SW-1:0] s_i,
  input  wire ymeta_t               meta_i,
  output logic                      vld_o,
  output logic [TW-1:0]             t_o,
  output ymeta_t                    meta_o
);

  typedef struct packed {
    logic [4:0] k;
    ymeta_t     meta;
  } hmeta_t;

  // normalize front end
  logic [30:0] sc;
  logic [31:0] ma;
  logic [30:0] b;
  logic [4:0]  msb;
  ymeta_t      m0;

  always_comb begin
    if (s_i < 0) sc = '0;
    else if (s_i > $signed({2'b00, ONE_Q30})) sc = ONE_Q30[30:0];
    else sc = s_i[30:0];
    ma = ONE_Q30 + 32'(sc);
    b  = ONE_Q30[30:0] - sc;
    msb = '0;
    for (int i = 0; i < 31; i++) begin
      if (b[i]) msb = 5'(i);
    end
    m0 = meta_i;
    m0.pole = (b == '0);
  end

  logic        l0_vld_r;
  logic [31:0] l0_ma_r;
  logic [30:0] l0_b_r;
  hmeta_t      l0_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) l0_vld_r <= 1'b0;
    else if (en) l0_vld_r <= vld_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l0_ma_r <= ma;
      l0_b_r  <= b;
      l0_h_r  <= '{k: 5'd30 - msb, meta: m0};
    end
  end

  // shift to the normalized mantissa and form sum and difference
  logic [30:0] mb;
  assign mb = l0_b_r << l0_h_r.k;

  logic                 l1_vld_r;
  logic signed [HW-1:0] l1_x_r, l1_y_r;
  hmeta_t               l1_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) l1_vld_r <= 1'b0;
    else if (en) l1_vld_r <= l0_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1_x_r <= $signed(HW'(l0_ma_r)) + $signed(HW'(mb));
      l1_y_r <= $signed(HW'(l0_ma_r)) - $signed(HW'(mb));
      l1_h_r <= l0_h_r;
    end
  end

  // hyperbolic vectoring steps
  logic                  hv_r [HYP_STEPS];
  logic signed [HW-1:0]  hx_r [HYP_STEPS];
  logic signed [HW-1:0]  hy_r [HYP_STEPS];
  logic signed [HZW-1:0] hz_r [HYP_STEPS];
  hmeta_t                hm_r [HYP_STEPS];

  for (genvar j = 0; j < HYP_STEPS; j++) begin : g_hyp
    localparam int SH = hyp_sh(j);
    logic                  va;
    logic signed [HW-1:0]  xa, ya;
    logic signed [HZW-1:0] za;
    hmeta_t                ma_h;

    if (j == 0) begin : g_head
      assign va   = l1_vld_r;
      assign xa   = l1_x_r;
      assign ya   = l1_y_r;
      assign za   = '0;
      assign ma_h = l1_h_r;
    end else begin : g_body
      assign va   = hv_r[j-1];
      assign xa   = hx_r[j-1];
      assign ya   = hy_r[j-1];
      assign za   = hz_r[j-1];
      assign ma_h = hm_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) hv_r[j] <= 1'b0;
      else if (en) hv_r[j] <= va;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (ya >= 0) begin
          hx_r[j] <= xa - (ya >>> SH);
          hy_r[j] <= ya - (xa >>> SH);
          hz_r[j] <= za + $signed(HZW'(HYP_TAB[SH-1]));
        end else begin
          hx_r[j] <= xa + (ya >>> SH);
          hy_r[j] <= ya + (xa >>> SH);
          hz_r[j] <= za - $signed(HZW'(HYP_TAB[SH-1]));
        end
        hm_r[j] <= ma_h;
      end
    end
  end

  // log ratio: twice atanh plus exponent difference times ln2
  logic signed [37:0] lsum;
  logic [34:0]        kprod;
  assign kprod = 35'(hm_r[HYP_STEPS-1].k) * 35'(LN2_Q30);
  assign lsum  = (38'(hz_r[HYP_STEPS-1]) <<< 1) + $signed({3'b000, kprod});

  logic        c1_vld_r;
  logic [35:0] c1_l_r;
  ymeta_t      c1_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c1_vld_r <= 1'b0;
    else if (en) c1_vld_r <= hv_r[HYP_STEPS-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_l_r <= (lsum < 0) ? '0 : lsum[35:0];
      c1_m_r <= hm_r[HYP_STEPS-1].meta;
    end
  end

  // scale by 1/pi as two partial products
  logic        c2_vld_r;
  logic [46:0] c2_ph_r, c2_pl_r;
  ymeta_t      c2_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c2_vld_r <= 1'b0;
    else if (en) c2_vld_r <= c1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_ph_r <= 47'(c1_l_r[35:18]) * 47'(INV_PI);
      c2_pl_r <= 47'(c1_l_r[17:0]) * 47'(INV_PI);
      c2_m_r  <= c1_m_r;
    end
  end

  // sum partials and round
  logic [65:0] psum;
  assign psum = (66'(c2_ph_r) << 18) + 66'(c2_pl_r) + (66'(1) << 29);

  logic          c3_vld_r;
  logic [TW-1:0] c3_t_r;
  ymeta_t        c3_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c3_vld_r <= 1'b0;
    else if (en) c3_vld_r <= c2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_t_r <= psum[30 +: TW];
      c3_m_r <= c2_m_r;
    end
  end

  assign vld_o  = c3_vld_r;
  assign t_o    = c3_t_r;
  assign meta_o = c3_m_r;

endmodule

`default_nettype wire

### sv/mrc_checker.sv
// ----------------------------------------------------------------------------
// mrc_checker: port-level checks of the projection block
// Watches the request and result handshakes of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [30:0] pixel_x,
  input wire logic [30:0] pixel_y
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y))
    else $error("result changed while stalled");

  // input only backs up behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("request refused without output stall");

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled cycle takes no request
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !(in_valid && in_ready))
    else $error("request taken during stall");

endmodule

bind latlng_to_mercator_pixel mrc_checker u_mrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .pixel_x   (out_ch.pixel_x),
  .pixel_y   (out_ch.pixel_y)
);

`default_nettype wire
